// File: hw/rtl/split_information_gain_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the split information gain block
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPLIT_INFORMATION_GAIN_MACROS_SVH
`define SPLIT_INFORMATION_GAIN_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define SIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define SIG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sig_pkg.sv
// ----------------------------------------------------------------------------
// sig_pkg
// Widths, types and saturating helpers shared by the information gain block.
// ----------------------------------------------------------------------------
package sig_pkg;

  localparam int COUNT_BITS = 20;
  localparam int FRAC_BITS  = 16;

  // Input counts and saturating side totals.
  localparam int FIELD_W = COUNT_BITS + 1;
  // Sum of two counts or of the two totals.
  localparam int SUM_W   = FIELD_W + 1;
  // Exponent of the log and the full fixed-point log value.
  localparam int EXP_W   = $clog2(SUM_W);
  localparam int LOG_W   = EXP_W + FRAC_BITS;
  // Q1.31 mantissa of the log unit.
  localparam int MANT_W  = 32;
  // n * log2(n) and the saturating sums of it.
  localparam int NLOGN_W = SUM_W + LOG_W;
  localparam int ACC_W   = 42;
  // Numerator of the final division: one n*log2(n) plus two sums.
  localparam int NUM_W   = NLOGN_W + 2;
  localparam int GAIN_W  = 20;

  localparam logic [FIELD_W-1:0] TOTAL_MAX = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [1:0] {
    NL_IDLE,
    NL_SQUARE,
    NL_MUL
  } nl_state_e;

  typedef enum logic {
    DV_IDLE,
    DV_RUN
  } dv_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_DIFF,
    ST_DIV,
    ST_PUSH
  } top_state_e;

  typedef enum logic [2:0] {
    SEL_A,
    SEL_B,
    SEL_AB,
    SEL_S,
    SEL_S0,
    SEL_S1
  } log_sel_e;

  function automatic logic [FIELD_W-1:0] sat_total(logic [FIELD_W-1:0] tot,
                                                   logic [FIELD_W-1:0] inc);
    logic [FIELD_W:0] sum;
    sum = {1'b0, tot} + {1'b0, inc};
    if (sum[FIELD_W]) begin
      return TOTAL_MAX;
    end
    return sum[FIELD_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_acc(logic [ACC_W-1:0]   acc,
                                               logic [NLOGN_W-1:0] inc);
    logic [NLOGN_W:0] sum;
    sum = (NLOGN_W + 1)'(acc) + (NLOGN_W + 1)'(inc);
    if (sum > (NLOGN_W + 1)'(ACC_MAX)) begin
      return ACC_MAX;
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

// File: hw/rtl/sig_nlogn.sv
// ----------------------------------------------------------------------------
// sig_nlogn
// Computes n * log2(n) in fixed point with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module sig_nlogn (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sig_pkg::SUM_W-1:0]    n_i,
  output sig_pkg::unit_stat_t          stat_o,
  output logic [sig_pkg::NLOGN_W-1:0]  nlogn_o
);
  import sig_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  nl_state_e              state_q, state_d;
  logic [SUM_W-1:0]       n_q, n_d;
  logic [MANT_W-1:0]      m_q, m_d;
  logic [EXP_W-1:0]       e_q, e_d;
  logic [FRAC_BITS:0]     bits_q, bits_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [NLOGN_W-1:0]     res_q, res_d;
  logic                   done_q, done_d;

  logic [EXP_W-1:0]       lead;
  logic [MANT_W-1:0]      norm;
  logic [MANT_W-1:0]      op_a, op_b;
  logic [2*MANT_W-1:0]    prod;
  logic [MANT_W:0]        sq;
  logic [FRAC_BITS:0]     rnd;
  logic [LOG_W-1:0]       lg;

  // Position of the leading one; zero input yields zero and a zero log.
  always_comb begin
    lead = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (n_i[i]) begin
        lead = EXP_W'(i);
      end
    end
  end

  assign norm = MANT_W'(n_i) << (6'(MANT_W - 1) - 6'(lead));

  // Rounding an all-ones fraction carries into the integer part.
  assign rnd  = (FRAC_BITS + 1)'(({1'b0, bits_q} + (FRAC_BITS + 2)'(1)) >> 1);
  assign lg   = {e_q, FRAC_BITS'(0)} + LOG_W'(rnd);

  // The single multiplier squares the mantissa, then forms n * log2(n).
  assign op_a = (state_q == NL_MUL) ? MANT_W'(n_q) : m_q;
  assign op_b = (state_q == NL_MUL) ? MANT_W'(lg)  : m_q;
  assign prod = op_a * op_b;
  assign sq   = prod[2*MANT_W-1:MANT_W-1];

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    m_d     = m_q;
    e_d     = e_q;
    bits_d  = bits_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      NL_IDLE: begin
        if (start_i) begin
          n_d     = n_i;
          m_d     = norm;
          e_d     = lead;
          bits_d  = '0;
          cnt_d   = '0;
          state_d = NL_SQUARE;
        end
      end
      NL_SQUARE: begin
        // A square at or above two gives a one bit and is halved.
        if (sq[MANT_W]) begin
          m_d    = sq[MANT_W:1];
          bits_d = {bits_q[FRAC_BITS-1:0], 1'b1};
        end else begin
          m_d    = sq[MANT_W-1:0];
          bits_d = {bits_q[FRAC_BITS-1:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FRAC_BITS)) begin
          state_d = NL_MUL;
        end
      end
      NL_MUL: begin
        res_d   = prod[NLOGN_W-1:0];
        done_d  = 1'b1;
        state_d = NL_IDLE;
      end
      default: begin
        state_d = NL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NL_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    m_q    <= m_d;
    e_q    <= e_d;
    bits_q <= bits_d;
    res_q  <= res_d;
  end

  assign stat_o.busy = (state_q != NL_IDLE);
  assign stat_o.done = done_q;
  assign nlogn_o     = res_q;

endmodule

// File: hw/rtl/sig_div.sv
// ----------------------------------------------------------------------------
// sig_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module sig_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sig_pkg::NUM_W-1:0]   num_i,
  input  logic [sig_pkg::SUM_W-1:0]   den_i,
  output sig_pkg::unit_stat_t         stat_o,
  output logic [sig_pkg::GAIN_W-1:0]  quot_o
);
  import sig_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);

  dv_state_e          state_q, state_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   den_q, den_d;
  logic [GAIN_W-1:0]  quot_q, quot_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;

  logic [SUM_W:0]     trial;
  logic               fits;

  assign trial = {rem_q, quot_q[GAIN_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          den_d = den_i;
          if (den_i == '0) begin
            quot_d = '0;
            done_d = 1'b1;
          end else if (num_i >= NUM_W'({den_i, GAIN_W'(0)})) begin
            // Quotient does not fit the result width.
            quot_d = '1;
            done_d = 1'b1;
          end else begin
            // The upper part is below the divisor, so only the low bits remain.
            rem_d   = num_i[GAIN_W +: SUM_W];
            quot_d  = num_i[GAIN_W-1:0];
            cnt_d   = '0;
            state_d = DV_RUN;
          end
        end
      end
      DV_RUN: begin
        if (fits) begin
          rem_d = SUM_W'(trial - {1'b0, den_q});
        end else begin
          rem_d = trial[SUM_W-1:0];
        end
        quot_d = {quot_q[GAIN_W-2:0], fits};
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(GAIN_W - 1)) begin
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = (state_q != DV_IDLE);
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// File: hw/rtl/split_information_gain.sv
// ----------------------------------------------------------------------------
// split_information_gain
// Information gain of a binary split from per-class counts of both sides.
// ----------------------------------------------------------------------------
// Each n*log2(n) runs 17 squaring steps on the shared multiplier, then a multiply.
// A class request occupies the block for three such evaluations.
// A request marked last adds three more, the subtraction and a divider of one
// quotient bit per cycle (skipped when the total is zero or the quotient
// saturates); its gain then waits while an earlier gain is still not taken.
// Reset is asynchronous, active low, and clears the side totals and n*log2(n) sums.
module split_information_gain (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sig_pkg::FIELD_W-1:0]  count_not_taken_i,
  input  logic [sig_pkg::FIELD_W-1:0]  count_taken_i,
  input  logic                         last_class_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sig_pkg::GAIN_W-1:0]   gain_o
);
  import sig_pkg::*;

  `include "split_information_gain_macros.svh"

  top_state_e          state_q, state_d;
  log_sel_e            sel_q, sel_d;
  logic                last_q, last_d;
  logic [FIELD_W-1:0]  a_q, a_d;
  logic [FIELD_W-1:0]  b_q, b_d;
  logic [FIELD_W-1:0]  tot_nt_q, tot_nt_d;
  logic [FIELD_W-1:0]  tot_t_q, tot_t_d;
  logic [ACC_W-1:0]    acc_nt_q, acc_nt_d;
  logic [ACC_W-1:0]    acc_t_q, acc_t_d;
  logic [ACC_W-1:0]    acc_c_q, acc_c_d;
  logic [NUM_W-1:0]    pos_q, pos_d;
  logic [NUM_W-1:0]    neg_q, neg_d;
  logic [NUM_W-1:0]    diff_q, diff_d;
  logic [GAIN_W-1:0]   gain_q, gain_d;
  logic                out_valid_q, out_valid_d;
  logic                nl_start_q, nl_start_d;
  logic                dv_start_q, dv_start_d;

  logic [SUM_W-1:0]    nl_n;
  logic [SUM_W-1:0]    total_sum;
  logic [NLOGN_W-1:0]  nl_res;
  logic [GAIN_W-1:0]   dv_quot;
  unit_stat_t          nl_stat;
  unit_stat_t          dv_stat;

  assign total_sum = SUM_W'(tot_nt_q) + SUM_W'(tot_t_q);

  always_comb begin
    case (sel_q)
      SEL_A:   nl_n = SUM_W'(a_q);
      SEL_B:   nl_n = SUM_W'(b_q);
      SEL_AB:  nl_n = SUM_W'(a_q) + SUM_W'(b_q);
      SEL_S:   nl_n = total_sum;
      SEL_S0:  nl_n = SUM_W'(tot_nt_q);
      SEL_S1:  nl_n = SUM_W'(tot_t_q);
      default: nl_n = '0;
    endcase
  end

  sig_nlogn u_nlogn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nl_start_q),
    .n_i     (nl_n),
    .stat_o  (nl_stat),
    .nlogn_o (nl_res)
  );

  sig_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start_q),
    .num_i   (diff_q),
    .den_i   (total_sum),
    .stat_o  (dv_stat),
    .quot_o  (dv_quot)
  );

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    last_d      = last_q;
    a_d         = a_q;
    b_d         = b_q;
    tot_nt_d    = tot_nt_q;
    tot_t_d     = tot_t_q;
    acc_nt_d    = acc_nt_q;
    acc_t_d     = acc_t_q;
    acc_c_d     = acc_c_q;
    pos_d       = pos_q;
    neg_d       = neg_q;
    diff_d      = diff_q;
    gain_d      = gain_q;
    out_valid_d = out_valid_q;
    nl_start_d  = 1'b0;
    dv_start_d  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          a_d        = count_not_taken_i;
          b_d        = count_taken_i;
          last_d     = last_class_i;
          tot_nt_d   = sat_total(tot_nt_q, count_not_taken_i);
          tot_t_d    = sat_total(tot_t_q, count_taken_i);
          sel_d      = SEL_A;
          nl_start_d = 1'b1;
          state_d    = ST_LOG;
        end
      end
      ST_LOG: begin
        if (nl_stat.done) begin
          unique case (sel_q)
            SEL_A: begin
              acc_nt_d   = sat_acc(acc_nt_q, nl_res);
              sel_d      = SEL_B;
              nl_start_d = 1'b1;
            end
            SEL_B: begin
              acc_t_d    = sat_acc(acc_t_q, nl_res);
              sel_d      = SEL_AB;
              nl_start_d = 1'b1;
            end
            SEL_AB: begin
              acc_c_d = sat_acc(acc_c_q, nl_res);
              if (last_q) begin
                sel_d      = SEL_S;
                nl_start_d = 1'b1;
              end else begin
                state_d = ST_IDLE;
              end
            end
            SEL_S: begin
              pos_d      = NUM_W'(nl_res) + NUM_W'(acc_nt_q);
              sel_d      = SEL_S0;
              nl_start_d = 1'b1;
            end
            SEL_S0: begin
              pos_d      = pos_q + NUM_W'(acc_t_q);
              neg_d      = NUM_W'(acc_c_q) + NUM_W'(nl_res);
              sel_d      = SEL_S1;
              nl_start_d = 1'b1;
            end
            SEL_S1: begin
              neg_d   = neg_q + NUM_W'(nl_res);
              state_d = ST_DIFF;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIFF: begin
        // A numerator at or below zero gives a gain of zero.
        diff_d     = (pos_q > neg_q) ? (pos_q - neg_q) : '0;
        dv_start_d = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        if (dv_stat.done) begin
          tot_nt_d = '0;
          tot_t_d  = '0;
          acc_nt_d = '0;
          acc_t_d  = '0;
          acc_c_d  = '0;
          state_d  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          gain_d      = dv_quot;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= SEL_A;
      last_q      <= 1'b0;
      tot_nt_q    <= '0;
      tot_t_q     <= '0;
      acc_nt_q    <= '0;
      acc_t_q     <= '0;
      acc_c_q     <= '0;
      out_valid_q <= 1'b0;
      nl_start_q  <= 1'b0;
      dv_start_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      last_q      <= last_d;
      tot_nt_q    <= tot_nt_d;
      tot_t_q     <= tot_t_d;
      acc_nt_q    <= acc_nt_d;
      acc_t_q     <= acc_t_d;
      acc_c_q     <= acc_c_d;
      out_valid_q <= out_valid_d;
      nl_start_q  <= nl_start_d;
      dv_start_q  <= dv_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    pos_q  <= pos_d;
    neg_q  <= neg_d;
    diff_q <= diff_d;
    gain_q <= gain_d;
  end

  assign out_valid_o = out_valid_q;
  assign gain_o      = gain_q;

  `SIG_ASSERT(a_start_log_idle, nl_start_q |-> !nl_stat.busy, "log unit started while busy")
  `SIG_ASSERT(a_ready_units_idle, in_ready_o |-> (!nl_stat.busy && !dv_stat.busy),
              "ready while an arithmetic unit is busy")
  `SIG_ASSERT(a_out_from_push, $rose(out_valid_o) |-> $past(state_q == ST_PUSH),
              "result shown without a finished division")
  `SIG_ASSERT_NEXT(a_accept_blocks, in_valid_i && in_ready_o, !in_ready_o,
                   "ready stayed high after a request was accepted")

endmodule

// File: test/split_information_gain_checker.sv
// ----------------------------------------------------------------------------
// split_information_gain_checker
// Watches both channels of the information gain block. Each accepted class
// request updates a private copy of the side totals and n*log2(n) sums. A
// request marked last queues the expected gain. Each accepted gain is checked
// against the oldest queued value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module split_information_gain_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [sig_pkg::FIELD_W-1:0] count_not_taken_i,
  input  logic [sig_pkg::FIELD_W-1:0] count_taken_i,
  input  logic                        last_class_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [sig_pkg::GAIN_W-1:0]  gain_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  import sig_pkg::*;

  localparam logic [63:0] TOTAL_CAP = (64'd1 << FIELD_W) - 64'd1;
  localparam logic [63:0] SUM_CAP   = (64'd1 << ACC_W) - 64'd1;
  localparam logic [63:0] GAIN_CAP  = (64'd1 << GAIN_W) - 64'd1;
  localparam logic [63:0] WIDE_CAP  = '1;
  localparam int          REPORT_MAX = 10;

  logic [63:0]       rows_not_taken;
  logic [63:0]       rows_taken;
  logic [63:0]       entropy_not_taken;
  logic [63:0]       entropy_taken;
  logic [63:0]       entropy_both;
  logic [GAIN_W-1:0] gain_expect_q[$];
  int                mismatches;

  function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] cap);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s > {1'b0, cap}) begin
      return cap;
    end
    return s[63:0];
  endfunction

  // Fixed-point log2: integer part from the leading one, fraction bits by
  // repeated squaring of a Q1.31 mantissa, plus one guard bit that rounds
  // half up.
  function automatic logic [63:0] fx_log2(input logic [63:0] n);
    logic [63:0] m;
    logic [63:0] bits;
    int          e;
    if (n == 64'd0) begin
      return 64'd0;
    end
    e = 0;
    while (e < 63 && (n >> (e + 1)) != 64'd0) begin
      e++;
    end
    m = (e > 31) ? (n >> (e - 31)) : (n << (31 - e));
    bits = 64'd0;
    for (int i = 0; i < FRAC_BITS + 1; i++) begin
      m = (m * m) >> 31;
      bits = bits << 1;
      if (m >= 64'h1_0000_0000) begin
        bits[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(e) << FRAC_BITS) + ((bits + 64'd1) >> 1);
  endfunction

  function automatic logic [63:0] n_log2_n(input logic [63:0] n);
    return n * fx_log2(n);
  endfunction

  task automatic absorb_class(input logic [63:0] a, input logic [63:0] b,
                              input logic last);
    logic [63:0] total;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] quo;
    rows_not_taken    = sat_add(rows_not_taken, a, TOTAL_CAP);
    rows_taken        = sat_add(rows_taken, b, TOTAL_CAP);
    entropy_not_taken = sat_add(entropy_not_taken, n_log2_n(a), SUM_CAP);
    entropy_taken     = sat_add(entropy_taken, n_log2_n(b), SUM_CAP);
    entropy_both      = sat_add(entropy_both, n_log2_n(a + b), SUM_CAP);
    if (last) begin
      total = rows_not_taken + rows_taken;
      quo = 64'd0;
      if (total != 64'd0) begin
        pos = sat_add(n_log2_n(total), entropy_not_taken, WIDE_CAP);
        pos = sat_add(pos, entropy_taken, WIDE_CAP);
        neg = sat_add(entropy_both, n_log2_n(rows_not_taken), WIDE_CAP);
        neg = sat_add(neg, n_log2_n(rows_taken), WIDE_CAP);
        // A numerator at or below zero leaves the gain at zero.
        if (pos > neg) begin
          quo = (pos - neg) / total;
          if (quo > GAIN_CAP) begin
            quo = GAIN_CAP;
          end
        end
      end
      gain_expect_q.insert(gain_expect_q.size(), quo[GAIN_W-1:0]);
      rows_not_taken    = 64'd0;
      rows_taken        = 64'd0;
      entropy_not_taken = 64'd0;
      entropy_taken     = 64'd0;
      entropy_both      = 64'd0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [GAIN_W-1:0] want;
    if (!rst_ni) begin
      rows_not_taken    = 64'd0;
      rows_taken        = 64'd0;
      entropy_not_taken = 64'd0;
      entropy_taken     = 64'd0;
      entropy_both      = 64'd0;
      mismatches        = 0;
      gain_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (gain_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: gain %0d arrived with no split pending", $realtime, gain_i);
          end
        end else begin
          want = gain_expect_q.pop_front();
          if (gain_i !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: gain mismatch: expected %0d (0x%05h), got %0d (0x%05h)",
                       $realtime, want, want, gain_i, gain_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        absorb_class(64'(count_not_taken_i), 64'(count_taken_i), last_class_i);
      end
      fail_count_o <= mismatches;
      pending_o    <= gain_expect_q.size();
    end
  end

endmodule

// File: test/split_information_gain_test.sv
// ----------------------------------------------------------------------------
// split_information_gain_test
// Drives class requests into the information gain block: a directed set of
// corner splits, then random splits under three idling patterns. The checker
// beside the block predicts and compares each gain; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module split_information_gain_test;

  import sig_pkg::*;

  localparam int                 CYCLE_LIMIT     = 1_000_000;
  localparam int                 ITEMS_PER_PHASE = 250;
  localparam int                 DRAIN_CYCLES    = 300;
  localparam logic [FIELD_W-1:0] CNT_MAX         = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [FIELD_W-1:0] count_not_taken_i;
  logic [FIELD_W-1:0] count_taken_i;
  logic               last_class_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [GAIN_W-1:0]  gain_o;

  int tx_idle_pct  = 33;
  int rx_stall_pct = 56;
  int cycles       = 0;
  int fail_count;
  int pending;

  split_information_gain i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .count_not_taken_i (count_not_taken_i),
    .count_taken_i     (count_taken_i),
    .last_class_i      (last_class_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .gain_o            (gain_o)
  );

  split_information_gain_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .count_not_taken_i (count_not_taken_i),
    .count_taken_i     (count_taken_i),
    .last_class_i      (last_class_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .gain_i            (gain_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** split_information_gain: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_class(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                            input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    count_not_taken_i <= a;
    count_taken_i     <= b;
    last_class_i      <= last;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  // Mostly small counts, with zeros, saturating values and full-width
  // patterns mixed in so that every bit of both fields moves.
  function automatic logic [FIELD_W-1:0] rand_count();
    case ($urandom_range(9))
      0: begin
        return '0;
      end
      1: begin
        return CNT_MAX;
      end
      2, 3: begin
        return FIELD_W'($urandom);
      end
      4: begin
        return FIELD_W'($urandom_range(65535));
      end
      default: begin
        return FIELD_W'($urandom_range(1, 1000));
      end
    endcase
  endfunction

  task automatic send_random_splits(input int n_items);
    int sent;
    int n_classes;
    sent = 0;
    while (sent < n_items) begin
      n_classes = $urandom_range(1, 8);
      for (int k = 0; k < n_classes; k++) begin
        send_class(rand_count(), rand_count(), k == n_classes - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    in_valid_i        <= 1'b0;
    count_not_taken_i <= '0;
    count_taken_i     <= '0;
    last_class_i      <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A split with no rows at all.
    send_class('0, '0, 1'b1);
    // One side empty, the other full.
    send_class(CNT_MAX, '0, 1'b1);
    send_class('0, CNT_MAX, 1'b1);
    // Perfect separation gives exactly one bit.
    send_class(21'd100, '0, 1'b0);
    send_class('0, 21'd100, 1'b1);
    // Even proportions carry no information; rounding may go negative.
    send_class(21'd3, 21'd3, 1'b0);
    send_class(21'd5, 21'd5, 1'b0);
    send_class(21'd7, 21'd7, 1'b1);
    // The combined sum saturates.
    send_class(CNT_MAX, CNT_MAX, 1'b1);
    // Side totals and all three sums saturate, and the quotient clips.
    send_class(CNT_MAX, '0, 1'b0);
    send_class(CNT_MAX, 21'd1, 1'b0);
    send_class(21'd1, CNT_MAX, 1'b0);
    send_class('0, CNT_MAX, 1'b1);
    // A class with no rows in the middle of a split.
    send_class(21'd1, 21'd1, 1'b0);
    send_class('0, '0, 1'b0);
    send_class(21'd2, 21'd1, 1'b1);
    send_class(21'h155555, 21'h0aaaaa, 1'b0);
    send_class(21'h0aaaaa, 21'h155555, 1'b1);
    send_class(21'd1, '0, 1'b1);

    send_random_splits(ITEMS_PER_PHASE);
    tx_idle_pct = 56;
    rx_stall_pct <= 33;
    send_random_splits(ITEMS_PER_PHASE);
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    send_random_splits(ITEMS_PER_PHASE);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** split_information_gain: PASSED **");
    end else begin
      $display("** split_information_gain: FAILED **");
    end
    $finish;
  end

endmodule
